>>> hdl/flsa_pkg.sv
// Package: operation and status codes, controller states and defaults of the slot allocator.
`default_nettype none
package flsa_pkg;

    localparam int unsigned MAX_SLOTS_DEF = 1024;

    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned BYTES_W  = 13;
    localparam int unsigned CFG_W    = 13;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OFFSET_W = 22;

    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = 13'd8;

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 2'd0,
        OP_GET     = 2'd1,
        OP_FREE    = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic {
        CFG_SLOT_COUNT = 1'b0,
        CFG_SLOT_BYTES = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_GET
    } t_state;

endpackage
`default_nettype wire

>>> hdl/free_list_slot_allocator.sv
// Top level: free-list slot allocator with link memory and head register.
//
//  channel   ports                                            handshake
//  command   i_operation, i_slot_index                        i_start & !o_busy
//  result    o_status, o_granted_slot, o_byte_offset          o_valid, one cycle
//  config    i_cfg_idx, i_cfg_data                            i_cfg_we
//
// Free, release and an exhausted get are handled in the idle state; o_valid follows the next cycle.
// A get with a free slot goes through a link memory read, then a head update.
// Initialize writes one link a cycle, one link per effective slot; a zero count just empties the list.
// Reset empties the list; the link memory is not cleared. No output stall.
`default_nettype none
module free_list_slot_allocator #(
    parameter int unsigned MAX_SLOTS = flsa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic [flsa_pkg::OP_W-1:0]      i_operation,
    input  wire logic [flsa_pkg::SLOT_W-1:0]    i_slot_index,
    output logic                                o_valid,
    output logic      [flsa_pkg::STATUS_W-1:0]  o_status,
    output logic      [flsa_pkg::SLOT_W-1:0]    o_granted_slot,
    output logic      [flsa_pkg::OFFSET_W-1:0]  o_byte_offset,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [flsa_pkg::CFG_W-1:0]     i_cfg_data
);
    import flsa_pkg::*;

    localparam int unsigned AW = $clog2(MAX_SLOTS);
    localparam int unsigned LW = $clog2(MAX_SLOTS + 1);
    localparam logic [LW-1:0] LINK_NONE = LW'(MAX_SLOTS);

    t_state              r_state, n_state;
    logic [LW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_cnt, n_cnt;
    logic [COUNT_W-1:0]  r_slot_count;
    logic [BYTES_W-1:0]  r_slot_bytes;
    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [OFFSET_W-1:0] r_offset, n_offset;

    logic [LW-1:0]       w_eff;
    logic                w_head_ok;
    logic                w_accept;
    logic                w_last;
    logic [31:0]         w_prod;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [LW-1:0]       w_wr_data;
    logic [LW-1:0]       w_rd_data;

    flsa_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_SLOTS)
    ) u_link (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_head[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_eff     = (32'(r_slot_count) > 32'(MAX_SLOTS)) ? LINK_NONE : LW'(r_slot_count);
    assign w_head_ok = (32'(r_head) < 32'(MAX_SLOTS));
    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_last    = ((32'(r_cnt) + 32'd1) >= 32'(w_eff));
    assign w_prod    = 32'(r_head) * 32'(r_slot_bytes);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_slot    = '0;
        n_offset  = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt;
        w_wr_data = LINK_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_op'(i_operation))
                        OP_INIT: begin
                            n_cnt = '0;
                            if (w_eff == '0) begin
                                n_head  = LINK_NONE;
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_INIT;
                            end
                        end
                        OP_GET: begin
                            if (w_head_ok) begin
                                n_state = S_GET;
                            end else begin
                                n_head   = LINK_NONE;
                                n_valid  = 1'b1;
                                n_status = ST_EXHAUSTED;
                            end
                        end
                        OP_FREE: begin
                            n_valid = 1'b1;
                            if (32'(i_slot_index) >= 32'(w_eff)) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = AW'(i_slot_index);
                                w_wr_data = w_head_ok ? r_head : LINK_NONE;
                                n_head    = LW'(i_slot_index);
                            end
                        end
                        OP_RELEASE: begin
                            n_head  = LINK_NONE;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt;
                w_wr_data = w_last ? LINK_NONE : LW'(32'(r_cnt) + 32'd1);
                n_cnt     = AW'(32'(r_cnt) + 32'd1);
                if (w_last) begin
                    n_head  = '0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_GET: begin
                n_head   = w_rd_data;
                n_valid  = 1'b1;
                n_slot   = SLOT_W'(r_head);
                n_offset = w_prod[OFFSET_W-1:0];
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= LINK_NONE;
            r_cnt        <= '0;
            r_valid      <= 1'b0;
            r_slot_count <= SLOT_COUNT_RST;
            r_slot_bytes <= SLOT_BYTES_RST;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_SLOT_BYTES: r_slot_bytes <= i_cfg_data[BYTES_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_slot   <= n_slot;
        r_offset <= n_offset;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_granted_slot = r_slot;
    assign o_byte_offset  = r_offset;

endmodule
`default_nettype wire

>>> hdl/flsa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module flsa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> tb/flsa_checker.sv
// Checker for the free-list slot allocator: predicts each result word and compares it.
module flsa_checker #(
    parameter int unsigned MAX_SLOTS = flsa_pkg::MAX_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [flsa_pkg::OP_W-1:0]     i_operation,
    input  logic [flsa_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic                          i_valid,
    input  logic [flsa_pkg::STATUS_W-1:0] i_status,
    input  logic [flsa_pkg::SLOT_W-1:0]   i_granted_slot,
    input  logic [flsa_pkg::OFFSET_W-1:0] i_byte_offset,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [flsa_pkg::CFG_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import flsa_pkg::*;

    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot;
        logic [OFFSET_W-1:0]   offset;
    } t_alloc_word;

    localparam logic [COUNT_W-1:0] LINK_NONE = COUNT_W'(MAX_SLOTS);

    logic [COUNT_W-1:0] link_mem [0:MAX_SLOTS-1];
    logic [COUNT_W-1:0] head_q;
    logic [COUNT_W-1:0] cnt_q;
    logic [BYTES_W-1:0] bytes_q;

    t_alloc_word owed_words[$];
    int fails = 0;
    int reports = 0;
    int words_seen = 0;

    assign o_fail_count = fails;

    function automatic t_alloc_word run_free_list_op(t_op op, logic [SLOT_W-1:0] idx);
        t_alloc_word w;
        int unsigned n;
        int unsigned prod;
        logic [COUNT_W-1:0] slot;
        w = '{status: ST_OK, slot: '0, offset: '0};
        n = (cnt_q > MAX_SLOTS) ? MAX_SLOTS : int'(cnt_q);
        case (op)
            OP_INIT: begin
                for (int unsigned i = 0; i < n; i++)
                    link_mem[i] = (i + 1 < n) ? COUNT_W'(i + 1) : LINK_NONE;
                head_q = (n > 0) ? '0 : LINK_NONE;
            end
            OP_GET: begin
                if (head_q >= MAX_SLOTS) begin
                    head_q = LINK_NONE;
                    w.status = ST_EXHAUSTED;
                end else begin
                    slot = head_q;
                    head_q = link_mem[slot];
                    prod = 32'(slot) * 32'(bytes_q);
                    w.slot = slot[SLOT_W-1:0];
                    w.offset = prod[OFFSET_W-1:0];
                end
            end
            OP_FREE: begin
                if (idx >= n) begin
                    w.status = ST_BAD_INDEX;
                end else begin
                    link_mem[idx] = (head_q >= MAX_SLOTS) ? LINK_NONE : head_q;
                    head_q = COUNT_W'(idx);
                end
            end
            default: head_q = LINK_NONE;
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_word got;
        t_alloc_word want;
        if (!i_rst_n) begin
            head_q = LINK_NONE;
            cnt_q = SLOT_COUNT_RST;
            bytes_q = SLOT_BYTES_RST;
            owed_words.delete();
        end else begin
            if (i_valid) begin
                got = '{status: t_status'(i_status), slot: i_granted_slot,
                        offset: i_byte_offset};
                if (owed_words.size() == 0) begin
                    fails++;
                    if (reports < 10) begin
                        reports++;
                        $display("word %0d unexpected: status %0d slot %0d offset %0d",
                                 words_seen, got.status, got.slot, got.offset);
                    end
                end else begin
                    want = owed_words.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (reports < 10) begin
                            reports++;
                            $display("word %0d: want %0d/%0d/%0d, got %0d/%0d/%0d",
                                     words_seen, want.status, want.slot, want.offset,
                                     got.status, got.slot, got.offset);
                        end
                    end
                end
                words_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOT_COUNT: cnt_q = i_cfg_data[COUNT_W-1:0];
                    CFG_SLOT_BYTES: bytes_q = i_cfg_data[BYTES_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                owed_words.push_back(run_free_list_op(t_op'(i_operation), i_slot_index));
        end
        o_owed = owed_words.size();
    end

    initial o_owed = 0;

endmodule

>>> tb/tb_free_list_slot_allocator.sv
// Testbench top: drives commands and pool settings into the slot allocator and gives the verdict.
module tb_free_list_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import flsa_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int unsigned POOL_MAX = MAX_SLOTS_DEF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [OP_W-1:0]       i_operation;
    logic [SLOT_W-1:0]     i_slot_index;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_W-1:0]     o_granted_slot;
    logic [OFFSET_W-1:0]   o_byte_offset;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;

    int fail_count;
    int owed;
    int word_no = 0;
    int pool_n = POOL_MAX;

    free_list_slot_allocator dut (.*);

    flsa_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_operation    (i_operation),
        .i_slot_index   (i_slot_index),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_granted_slot (o_granted_slot),
        .i_byte_offset  (o_byte_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_owed         (owed)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // one command word; random gaps before it except in the burst window
    task automatic send_word(t_op op, logic [SLOT_W-1:0] idx);
        if (!(word_no >= 150 && word_no < 230)) begin
            while ($urandom_range(0, 99) < 28) begin
                @(negedge i_clk);
                i_start = 1'b0;
            end
        end
        @(negedge i_clk);
        i_start = 1'b1;
        i_operation = op;
        i_slot_index = idx;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        word_no++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (owed != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_pool(logic [CFG_W-1:0] cnt_data, logic [CFG_W-1:0] bytes_data);
        settle();
        write_reg(CFG_SLOT_COUNT, cnt_data);
        write_reg(CFG_SLOT_BYTES, bytes_data);
        pool_n = (cnt_data[COUNT_W-1:0] > POOL_MAX) ? POOL_MAX : int'(cnt_data[COUNT_W-1:0]);
    endtask

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int c;
        int r;
        int q;
        logic [BYTES_W-1:0] b;
        logic [SLOT_W-1:0] idx;
        t_op op;

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_operation = OP_INIT;
        i_slot_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SLOT_COUNT;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: empty list, 1024 slots of 8 bytes
        send_word(OP_GET, 10'd0);
        send_word(OP_FREE, 10'd0);
        send_word(OP_GET, 10'd1023);
        send_word(OP_GET, 10'd0);
        send_word(OP_FREE, 10'd1023);
        send_word(OP_GET, 10'd0);

        set_pool(13'd3, 13'd8191);
        send_word(OP_INIT, 10'd1023);
        send_word(OP_GET, 10'd0);
        send_word(OP_GET, 10'd0);
        send_word(OP_GET, 10'd0);
        send_word(OP_GET, 10'd0);
        send_word(OP_FREE, 10'd3);
        send_word(OP_FREE, 10'd1023);
        send_word(OP_FREE, 10'd2);
        send_word(OP_GET, 10'd0);
        send_word(OP_RELEASE, 10'd0);
        send_word(OP_FREE, 10'd1);
        send_word(OP_GET, 10'd0);

        // count of zero, written with the upper data bits set
        set_pool(13'h1800, 13'd8191);
        send_word(OP_INIT, 10'd0);
        send_word(OP_GET, 10'd0);
        send_word(OP_FREE, 10'd0);

        // count above the pool saturates; offset wraps at 22 bits
        set_pool(13'd2047, 13'd8191);
        send_word(OP_FREE, 10'd1023);
        send_word(OP_GET, 10'd0);
        set_pool(13'd2047, 13'd4096);
        send_word(OP_FREE, 10'd1023);
        send_word(OP_GET, 10'd0);

        set_pool(13'd1, 13'd0);
        send_word(OP_INIT, 10'd0);
        send_word(OP_GET, 10'd0);
        send_word(OP_GET, 10'd0);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin c = 1024; b = 13'd4096; end
                1: begin c = 2047; b = 13'd8191; end
                2: begin c = 1; b = 13'd0; end
                default: begin
                    c = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 48);
                    r = $urandom_range(0, 3);
                    b = (r == 0) ? 13'd8 : (r == 1) ? 13'd4096 : 13'($urandom_range(0, 8191));
                end
            endcase
            set_pool({2'($urandom_range(0, 3)), 11'(c)}, b);
            send_word(OP_INIT, 10'($urandom_range(0, 1023)));
            for (int k = 0; k < 39; k++) begin
                r = $urandom_range(0, 99);
                op = (r < 44) ? OP_GET : (r < 86) ? OP_FREE : (r < 92) ? OP_INIT : OP_RELEASE;
                idx = 10'($urandom_range(0, 1023));
                if (op == OP_FREE) begin
                    q = $urandom_range(0, 99);
                    if (q < 75 && pool_n > 0)
                        idx = 10'($urandom_range(0, pool_n - 1));
                    else if (q < 88)
                        idx = (pool_n + 3 > 1023) ? 10'd1023
                                                  : 10'($urandom_range(pool_n, pool_n + 3));
                end
                send_word(op, idx);
            end
        end

        settle();
        repeat (1100) @(posedge i_clk);
        if (fail_count == 0 && owed == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
